### hdl/tfmm_pkg.sv
// Shared types, constants and helper functions for the three-frame motion mask.
package tfmm_pkg;

  localparam int CFG_W = 11;
  localparam int PIX_W = 8;
  localparam int IDX_W = 2;
  localparam int STORE_W = 4 * PIX_W;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DIFF_THRESHOLD = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 11'd480;
  localparam logic [PIX_W-1:0] RST_DIFF_THRESHOLD = 8'd5;

  // Q16 studio-range weights (0.114, 0.587, 0.299 scaled by 219/255)
  localparam logic [23:0] W_BLUE   = 24'd6416;
  localparam logic [23:0] W_GREEN  = 24'd33039;
  localparam logic [23:0] W_RED    = 24'd16829;
  localparam logic [PIX_W-1:0] LUMA_OFS = 8'd16;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  // sum stays below 2^24, integer part at most 219 so the offset cannot wrap
  function automatic logic [PIX_W-1:0] luma(input pixel_t p);
    logic [23:0] acc;
    acc = 24'(p.blue) * W_BLUE + 24'(p.green) * W_GREEN + 24'(p.red) * W_RED;
    return acc[23:16] + LUMA_OFS;
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### hdl/tfmm_in_if.sv
// Input pixel channel: valid/ready handshake with a BGR payload.
interface tfmm_in_if;
  logic                      valid;
  logic                      ready;
  logic [tfmm_pkg::PIX_W-1:0] in_blue;
  logic [tfmm_pkg::PIX_W-1:0] in_green;
  logic [tfmm_pkg::PIX_W-1:0] in_red;

  modport source (output valid, output in_blue, output in_green, output in_red,
                  input ready);
  modport sink   (input valid, input in_blue, input in_green, input in_red,
                  output ready);
endinterface

### hdl/tfmm_out_if.sv
// Result channel: valid/ready handshake with result pixel and flags.
interface tfmm_out_if;
  logic                      valid;
  logic                      ready;
  logic [tfmm_pkg::PIX_W-1:0] out_blue;
  logic [tfmm_pkg::PIX_W-1:0] out_green;
  logic [tfmm_pkg::PIX_W-1:0] out_red;
  logic                      moving;
  logic                      frame_end;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output moving, output frame_end, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input moving, input frame_end, output ready);
endinterface

### hdl/three_frame_motion_mask.sv
// Each input transaction passes the stage 1, stage 2 and output registers.
// Throughput: one pixel per cycle unless out_px.ready stalls; the store takes one
// read and one write per cycle; near-in-flight store updates are forwarded in the
// read stage. Reset is synchronous; afterwards a clearing pass writes zero to all
// MAX_WIDTH*MAX_HEIGHT store entries, one per cycle, with in_px.ready held low.
// Configuration writes are taken at any time, including during that pass.
module three_frame_motion_mask #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tfmm_in_if.sink                        in_px,
  tfmm_out_if.source                     out_px,
  input  logic                           cfg_we,
  input  logic [tfmm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tfmm_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_B   = $clog2(MAX_DIM + 1);
  localparam int DIM_W   = ((DIM_B > tfmm_pkg::CFG_W) ? DIM_B : tfmm_pkg::CFG_W) + 3;
  localparam int PW      = tfmm_pkg::PIX_W;
  localparam int SW      = tfmm_pkg::STORE_W;

  localparam logic [DIM_W-1:0]  MAXW_D    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]  MAXH_D    = DIM_W'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // configuration
  logic [tfmm_pkg::CFG_W-1:0] frame_width_r, frame_height_r;
  logic [PW-1:0]              diff_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= tfmm_pkg::RST_FRAME_WIDTH;
      frame_height_r   <= tfmm_pkg::RST_FRAME_HEIGHT;
      diff_threshold_r <= tfmm_pkg::RST_DIFF_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfmm_pkg::REG_FRAME_WIDTH:    frame_width_r    <= cfg_data;
        tfmm_pkg::REG_FRAME_HEIGHT:   frame_height_r   <= cfg_data;
        tfmm_pkg::REG_DIFF_THRESHOLD: diff_threshold_r <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size and centre window
  logic [DIM_W-1:0] w_cfg, h_cfg, w_eff, h_eff;
  logic [DIM_W-1:0] win_col_lo, win_col_hi, win_row_lo, win_row_hi;

  always_comb begin
    w_cfg = DIM_W'(frame_width_r);
    h_cfg = DIM_W'(frame_height_r);
    if (w_cfg == '0)          w_eff = DIM_W'(1);
    else if (w_cfg > MAXW_D)  w_eff = MAXW_D;
    else                      w_eff = w_cfg;
    if (h_cfg == '0)          h_eff = DIM_W'(1);
    else if (h_cfg > MAXH_D)  h_eff = MAXH_D;
    else                      h_eff = h_cfg;
    win_col_lo = w_eff >> 3;
    win_col_hi = ((w_eff << 3) - w_eff) >> 3;
    win_row_lo = h_eff >> 3;
    win_row_hi = ((h_eff << 3) - h_eff) >> 3;
  end

  // clearing pass after reset
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == LAST_ADDR) clearing_r <= 1'b0;
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // whole pipeline moves together; output register parts the two sides
  logic out_valid_r;
  logic adv, in_fire;

  assign adv         = !out_valid_r || out_px.ready;
  assign in_px.ready = adv && !clearing_r;
  assign in_fire     = in_px.valid && in_px.ready;

  // stage 0: raster position, store address, window test
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [ADDR_W-1:0] s0_addr;
  logic [DIM_W-1:0]  col_d, row_d;
  logic              s0_inside, last_col, last_row;

  always_comb begin
    col_d     = DIM_W'(col_r);
    row_d     = DIM_W'(row_r);
    s0_addr   = row_base_r + ADDR_W'(col_r);
    s0_inside = (col_d >= win_col_lo) && (col_d < win_col_hi) &&
                (row_d >= win_row_lo) && (row_d < win_row_hi);
    last_col  = (col_d + DIM_W'(1)) >= w_eff;
    last_row  = (row_d + DIM_W'(1)) >= h_eff;
    col_nxt      = col_r + COL_W'(1);
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    if (last_col) begin
      col_nxt = '0;
      if (last_row) begin
        row_nxt      = '0;
        row_base_nxt = '0;
      end else begin
        row_nxt      = row_r + ROW_W'(1);
        row_base_nxt = row_base_r + ROW_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
    end else if (in_fire) begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
    end
  end

  // store: {older luma, previous pixel}
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SW-1:0]     ram_wdata, ram_rdata;

  // stage 1 registers
  logic              s1_valid_r, s1_inside_r, s1_end_r;
  tfmm_pkg::pixel_t  s1_pix_r;
  logic [ADDR_W-1:0] s1_addr_r;

  // stage 2 registers
  logic              s2_valid_r, s2_inside_r, s2_end_r;
  tfmm_pkg::pixel_t  s2_pix_r, s2_prev_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [PW-1:0]     s2_ycur_r, s2_yprev_r, s2_yold_r;

  // write-back copy of the item in the output register
  logic [ADDR_W-1:0] wb_addr_r;
  tfmm_pkg::pixel_t  wb_pix_r;
  logic [PW-1:0]     wb_yprev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r    <= '{red: in_px.in_red, green: in_px.in_green, blue: in_px.in_blue};
      s1_addr_r   <= s0_addr;
      s1_inside_r <= s0_inside;
      s1_end_r    <= last_col && last_row;
    end
  end

  // stage 1: store data with forwarding of the two not yet visible writes, luma
  tfmm_pkg::pixel_t s1_prev;
  logic [PW-1:0]    s1_yold;

  always_comb begin
    if (s2_valid_r && (s2_addr_r == s1_addr_r)) begin
      s1_prev = s2_pix_r;
      s1_yold = s2_yprev_r;
    end else if (out_valid_r && (wb_addr_r == s1_addr_r)) begin
      s1_prev = wb_pix_r;
      s1_yold = wb_yprev_r;
    end else begin
      s1_prev = tfmm_pkg::pixel_t'(ram_rdata[3*PW-1:0]);
      s1_yold = ram_rdata[SW-1:3*PW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pix_r    <= s1_pix_r;
      s2_prev_r   <= s1_prev;
      s2_addr_r   <= s1_addr_r;
      s2_inside_r <= s1_inside_r;
      s2_end_r    <= s1_end_r;
      s2_ycur_r   <= tfmm_pkg::luma(s1_pix_r);
      s2_yprev_r  <= tfmm_pkg::luma(s1_prev);
      s2_yold_r   <= s1_yold;
    end
  end

  // stage 2: differences and result selection
  logic             s2_moving;
  tfmm_pkg::pixel_t s2_res;

  always_comb begin
    s2_moving = s2_inside_r &&
                (tfmm_pkg::abs_diff(s2_ycur_r, s2_yprev_r) > diff_threshold_r) &&
                (tfmm_pkg::abs_diff(s2_yprev_r, s2_yold_r) > diff_threshold_r);
    if (!s2_inside_r)   s2_res = s2_pix_r;
    else if (s2_moving) s2_res = s2_prev_r;
    else                s2_res = '0;
  end

  // output register
  tfmm_pkg::pixel_t out_pix_r;
  logic             out_moving_r, out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r    <= s2_res;
      out_moving_r <= s2_moving;
      out_end_r    <= s2_end_r;
      wb_addr_r    <= s2_addr_r;
      wb_pix_r     <= s2_pix_r;
      wb_yprev_r   <= s2_yprev_r;
    end
  end

  assign out_px.valid     = out_valid_r;
  assign out_px.out_blue  = out_pix_r.blue;
  assign out_px.out_green = out_pix_r.green;
  assign out_px.out_red   = out_pix_r.red;
  assign out_px.moving    = out_moving_r;
  assign out_px.frame_end = out_end_r;

  // store update leaves stage 2 as the item moves to the output register
  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = adv && s2_valid_r;
      ram_waddr = s2_addr_r;
      ram_wdata = {s2_yprev_r, s2_pix_r};
    end
  end

  tfmm_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (s0_addr),
    .rd_data (ram_rdata)
  );

endmodule

### hdl/tfmm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module tfmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
